// ===== rtl/fbad_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbad_pkg
// Shared types and constants of the flow burst anomaly detector.
// ----------------------------------------------------------------------------
package fbad_pkg;

	localparam int SLOTS_DEF = 256;
	localparam int DEPTH_DEF = 16;

	localparam int RATE_W  = 48;
	localparam int MULT_W  = 16;
	localparam int SEV_W   = 17;
	localparam int KEY_W   = 104;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_BURST_THR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SUSP_THR  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MULT      = 2'd2;

	localparam logic [MULT_W-1:0] MULT_RESET = 16'd512;
	localparam logic [MULT_W-1:0] MULT_SUSP  = 16'd512;
	localparam logic [MULT_W-1:0] MULT_HIGH  = 16'd384;
	localparam logic [MULT_W-1:0] MULT_ONE   = 16'd256;
	localparam logic [SEV_W-1:0]  SEV_FULL   = 17'd65536;
	localparam int SEV_STEPS = 16;

	typedef enum logic [1:0] {
		KIND_BURST = 2'd0,
		KIND_SUSP  = 2'd1,
		KIND_HIGH  = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_SCAN,
		OP_RESOLVE,
		OP_META,
		OP_APPEND,
		OP_SUM,
		OP_AVG,
		OP_MUL,
		OP_SEV_INIT,
		OP_SEV_CHK,
		OP_SEV_DIV,
		OP_EMIT
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESOLVE,
		ST_META,
		ST_APPEND,
		ST_BRANCH,
		ST_SUM,
		ST_AVG,
		ST_MUL,
		ST_CMP,
		ST_SEV_INIT,
		ST_SEV_CHK,
		ST_SEV_DIV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		op_t   op;
		kind_t kind;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic burst_go;
		logic sum_done;
		logic div_done;
		logic burst_hit;
		logic susp_hit;
		logic high_hit;
		logic sev_done;
	} status_t;

endpackage

// ===== rtl/flow_burst_anomaly_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_burst_anomaly_detector
// Per-flow byte-rate history with burst, suspicious and high-volume checks.
// ----------------------------------------------------------------------------
// Usage:
//   Input word: drive func and the flow fields, raise start; the word is
//   taken at an edge with start high and busy low. func=1 clears all flow
//   history at that same edge and gives no result.
//   Config: cfg_we/cfg_index/cfg_data write a threshold or the multiplier
//   at once; write only while busy is low.
//   Results: each result word is held for one cycle with result_valid high;
//   last marks the final word of an input. Up to three words per input
//   (burst, suspicious, high volume), in that order. There is no back
//   pressure: the receiver must take every word when it is shown.
//   Sequence: the flow table is scanned one slot a cycle, then the lookup
//   is resolved and the history updated. A burst check adds a history sum,
//   an average division and a multiply/compare. Each result word adds a
//   severity set-up and check, the 16-step division when severity needs it,
//   and the emit.
//   Reset: table empty, thresholds 0, multiplier 2.0; no clearing pass.
// ----------------------------------------------------------------------------
module flow_burst_anomaly_detector import fbad_pkg::*; #(
	parameter int FLOW_SLOTS    = SLOTS_DEF,
	parameter int HISTORY_DEPTH = DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  func,
	input  logic [31:0]           src_addr,
	input  logic [31:0]           dst_addr,
	input  logic [15:0]           src_port,
	input  logic [15:0]           dst_port,
	input  logic [7:0]            proto,
	input  logic [RATE_W-1:0]     flow_bps,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [RATE_W-1:0]     cfg_data,
	output logic                  result_valid,
	output logic [1:0]            kind,
	output logic [RATE_W-1:0]     rate_bps,
	output logic [RATE_W-1:0]     limit_bps,
	output logic [SEV_W-1:0]      severity,
	output logic                  last
);

	cmd_t    cmd;
	status_t stat;

	// sequencer: one state per step of the word's work
	fbad_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// storage and arithmetic, driven by the sequencer's commands
	fbad_dp #(
		.SLOTS (FLOW_SLOTS),
		.DEPTH (HISTORY_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.func         (func),
		.src_addr     (src_addr),
		.dst_addr     (dst_addr),
		.src_port     (src_port),
		.dst_port     (dst_port),
		.proto        (proto),
		.flow_bps     (flow_bps),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.kind         (kind),
		.rate_bps     (rate_bps),
		.limit_bps    (limit_bps),
		.severity     (severity),
		.last         (last)
	);

endmodule

// ===== rtl/fbad_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbad_ctrl
// Sequencer: walks one word through lookup, history, checks and results.
// ----------------------------------------------------------------------------
module fbad_ctrl import fbad_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    func,
	input  status_t stat,
	output cmd_t    cmd,
	output logic    busy
);

	state_t state_q, state_d;
	kind_t  kind_q, kind_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q  <= KIND_BURST;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		kind_d   = kind_q;
		cmd.op   = OP_NONE;
		cmd.kind = kind_q;
		busy     = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.op = OP_LOAD;
					if (!func) state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.op = OP_SCAN;
				if (stat.scan_done) state_d = ST_RESOLVE;
			end
			ST_RESOLVE: begin
				cmd.op  = OP_RESOLVE;
				state_d = ST_META;
			end
			ST_META: begin
				cmd.op  = OP_META;
				state_d = ST_APPEND;
			end
			ST_APPEND: begin
				cmd.op  = OP_APPEND;
				state_d = ST_BRANCH;
			end
			ST_BRANCH: begin
				if (stat.burst_go) begin
					state_d = ST_SUM;
				end else if (stat.susp_hit) begin
					kind_d  = KIND_SUSP;
					state_d = ST_SEV_INIT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SUM: begin
				cmd.op = OP_SUM;
				if (stat.sum_done) state_d = ST_AVG;
			end
			ST_AVG: begin
				cmd.op = OP_AVG;
				if (stat.div_done) state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.op  = OP_MUL;
				state_d = ST_CMP;
			end
			ST_CMP: begin
				if (stat.burst_hit) begin
					kind_d  = KIND_BURST;
					state_d = ST_SEV_INIT;
				end else if (stat.susp_hit) begin
					kind_d  = KIND_SUSP;
					state_d = ST_SEV_INIT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SEV_INIT: begin
				cmd.op  = OP_SEV_INIT;
				state_d = ST_SEV_CHK;
			end
			ST_SEV_CHK: begin
				cmd.op  = OP_SEV_CHK;
				state_d = ST_SEV_DIV;
			end
			ST_SEV_DIV: begin
				cmd.op = OP_SEV_DIV;
				if (stat.sev_done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.op = OP_EMIT;
				case (kind_q)
					KIND_BURST: begin
						if (stat.susp_hit) begin
							kind_d  = KIND_SUSP;
							state_d = ST_SEV_INIT;
						end else begin
							state_d = ST_IDLE;
						end
					end
					KIND_SUSP: begin
						if (stat.high_hit) begin
							kind_d  = KIND_HIGH;
							state_d = ST_SEV_INIT;
						end else begin
							state_d = ST_IDLE;
						end
					end
					default: state_d = ST_IDLE;
				endcase
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== rtl/fbad_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbad_dp
// Datapath: flow table, history rings, average divider, severity divider.
// ----------------------------------------------------------------------------
module fbad_dp import fbad_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF,
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output status_t               stat,
	input  logic                  func,
	input  logic [31:0]           src_addr,
	input  logic [31:0]           dst_addr,
	input  logic [15:0]           src_port,
	input  logic [15:0]           dst_port,
	input  logic [7:0]            proto,
	input  logic [RATE_W-1:0]     flow_bps,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [RATE_W-1:0]     cfg_data,
	output logic                  result_valid,
	output logic [1:0]            kind,
	output logic [RATE_W-1:0]     rate_bps,
	output logic [RATE_W-1:0]     limit_bps,
	output logic [SEV_W-1:0]      severity,
	output logic                  last
);

	localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int DW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int SUMW = RATE_W + CW;
	localparam int DCW  = $clog2(SUMW + 1);
	localparam int PW   = RATE_W + MULT_W;
	localparam int AW   = RATE_W + 8;
	localparam logic [SW:0]  SLOTS_C = (SW+1)'(SLOTS);
	localparam logic [DCW-1:0] SUMW_C = DCW'(SUMW);
	localparam logic [DW-1:0] HEAD_LAST = DW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [CW-1:0] MIN_CNT = CW'(3);

	// configuration
	logic [RATE_W-1:0] bthr_q, sthr_q;
	logic [MULT_W-1:0] mult_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bthr_q <= '0;
			sthr_q <= '0;
			mult_q <= MULT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BURST_THR: bthr_q <= cfg_data;
				CFG_SUSP_THR:  sthr_q <= cfg_data;
				CFG_MULT:      mult_q <= cfg_data[MULT_W-1:0];
				default: ;
			endcase
		end
	end

	// storage
	logic [KEY_W-1:0]      tup_mem  [SLOTS];
	logic [CW+DW-1:0]      meta_mem [SLOTS];
	logic [RATE_W-1:0]     ring_mem [SLOTS << DW];
	logic [SLOTS-1:0]      valid_q;
	logic [KEY_W-1:0]      tup_rd_q;
	logic [CW+DW-1:0]      meta_rd_q;
	logic [RATE_W-1:0]     ring_rd_q;

	// per-word state
	logic [KEY_W-1:0]  key_q;
	logic [RATE_W-1:0] rate_q;
	logic [SW:0]       idx_q;
	logic              pend_s1;
	logic [SW-1:0]     idx_s1;
	logic              hit_found_q, free_found_q, new_q, tracked_q;
	logic [SW-1:0]     hit_q, free_q, slot_q;
	logic [CW-1:0]     cnt_q, sidx_q;
	logic              spend_s1;
	logic [SUMW-1:0]   sum_q, dv_q;
	logic [CW-1:0]     drem_q;
	logic [DCW-1:0]    dcnt_q;
	logic [PW-1:0]     prod_q;
	logic [RATE_W-1:0] lim_q;
	logic [MULT_W-1:0] m_q;
	logic [63:0]       d_q, rem_q;
	logic [4:0]        scnt_q;
	logic              sev_run_q;
	logic [SEV_W-1:0]  sev_q;
	kind_t             kind_q;

	logic              scan_rd;
	logic [CW-1:0]     cur_cnt, nxt_cnt;
	logic [DW-1:0]     cur_head, nxt_head;
	logic              sum_rd;
	logic [CW:0]       dr2;
	logic              rate_gt_lim;
	logic [AW-1:0]     a_val;
	logic [63:0]       r2;
	logic              top;

	assign scan_rd  = (cmd.op == OP_SCAN) && (idx_q != SLOTS_C);
	assign sum_rd   = (cmd.op == OP_SUM) && (sidx_q != cnt_q);
	assign cur_cnt  = new_q ? '0 : meta_rd_q[CW+DW-1:DW];
	assign cur_head = new_q ? '0 : meta_rd_q[DW-1:0];
	assign nxt_cnt  = (cur_cnt < DEPTH_C) ? cur_cnt + CW'(1) : cur_cnt;
	assign nxt_head = (cur_head == HEAD_LAST) ? '0 : cur_head + DW'(1);
	assign dr2      = {drem_q, dv_q[SUMW-1]};
	assign rate_gt_lim = rate_q > lim_q;
	assign a_val    = {rate_q - lim_q, 8'd0};
	assign top      = rem_q[63];
	assign r2       = {rem_q[62:0], 1'b0};

	always_ff @(posedge clk) begin
		if (scan_rd) tup_rd_q <= tup_mem[idx_q[SW-1:0]];
		if (cmd.op == OP_RESOLVE && !hit_found_q && free_found_q) tup_mem[free_q] <= key_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_META) meta_rd_q <= meta_mem[slot_q];
		if (cmd.op == OP_APPEND && tracked_q) meta_mem[slot_q] <= {nxt_cnt, nxt_head};
	end

	always_ff @(posedge clk) begin
		if (sum_rd) ring_rd_q <= ring_mem[{slot_q, sidx_q[DW-1:0]}];
		if (cmd.op == OP_APPEND && tracked_q) ring_mem[{slot_q, cur_head}] <= rate_q;
	end

	// slot valid bits: clear command empties the table at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.op == OP_LOAD && func) begin
			valid_q <= '0;
		end else if (cmd.op == OP_RESOLVE && !hit_found_q && free_found_q) begin
			valid_q[free_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				key_q        <= {src_addr, dst_addr, src_port, dst_port, proto};
				rate_q       <= flow_bps;
				idx_q        <= '0;
				pend_s1      <= 1'b0;
				hit_found_q  <= 1'b0;
				free_found_q <= 1'b0;
			end
			OP_SCAN: begin
				pend_s1 <= scan_rd;
				idx_s1  <= idx_q[SW-1:0];
				if (scan_rd) idx_q <= idx_q + (SW+1)'(1);
				if (pend_s1) begin
					if (valid_q[idx_s1] && tup_rd_q == key_q && !hit_found_q) begin
						hit_found_q <= 1'b1;
						hit_q       <= idx_s1;
					end
					if (!valid_q[idx_s1] && !free_found_q) begin
						free_found_q <= 1'b1;
						free_q       <= idx_s1;
					end
				end
			end
			OP_RESOLVE: begin
				tracked_q <= hit_found_q || free_found_q;
				new_q     <= !hit_found_q;
				slot_q    <= hit_found_q ? hit_q : free_q;
			end
			OP_APPEND: begin
				cnt_q    <= nxt_cnt;
				sidx_q   <= '0;
				spend_s1 <= 1'b0;
				sum_q    <= '0;
			end
			OP_SUM: begin
				spend_s1 <= sum_rd;
				if (sum_rd) sidx_q <= sidx_q + CW'(1);
				if (spend_s1) sum_q <= sum_q + SUMW'(ring_rd_q);
				dv_q   <= sum_q;
				drem_q <= '0;
				dcnt_q <= '0;
			end
			OP_AVG: begin
				// restoring divide, one quotient bit a cycle
				if (dcnt_q != SUMW_C) begin
					dcnt_q <= dcnt_q + DCW'(1);
					if (dr2 >= {1'b0, cnt_q}) begin
						drem_q <= CW'(dr2 - {1'b0, cnt_q});
						dv_q   <= {dv_q[SUMW-2:0], 1'b1};
					end else begin
						drem_q <= dr2[CW-1:0];
						dv_q   <= {dv_q[SUMW-2:0], 1'b0};
					end
				end
			end
			OP_MUL: prod_q <= PW'(dv_q[RATE_W-1:0]) * PW'(mult_q);
			OP_SEV_INIT: begin
				kind_q <= cmd.kind;
				case (cmd.kind)
					KIND_BURST: begin
						lim_q <= bthr_q;
						m_q   <= mult_q;
						d_q   <= 64'(bthr_q) * 64'(mult_q - MULT_ONE);
					end
					KIND_SUSP: begin
						lim_q <= sthr_q;
						m_q   <= MULT_SUSP;
						d_q   <= 64'(sthr_q) * 64'(MULT_SUSP - MULT_ONE);
					end
					default: begin
						lim_q <= sthr_q;
						m_q   <= MULT_HIGH;
						d_q   <= 64'(sthr_q) * 64'(MULT_HIGH - MULT_ONE);
					end
				endcase
			end
			OP_SEV_CHK: begin
				scnt_q <= '0;
				rem_q  <= 64'(a_val);
				if (!rate_gt_lim) begin
					sev_q     <= '0;
					sev_run_q <= 1'b0;
				end else if (m_q <= MULT_ONE || lim_q == '0 || 64'(a_val) >= d_q) begin
					sev_q     <= SEV_FULL;
					sev_run_q <= 1'b0;
				end else begin
					sev_q     <= '0;
					sev_run_q <= 1'b1;
				end
			end
			OP_SEV_DIV: begin
				if (sev_run_q && scnt_q != 5'(SEV_STEPS)) begin
					scnt_q <= scnt_q + 5'd1;
					if (top || r2 >= d_q) begin
						rem_q <= r2 - d_q;
						sev_q <= {sev_q[SEV_W-2:0], 1'b1};
					end else begin
						rem_q <= r2;
						sev_q <= {sev_q[SEV_W-2:0], 1'b0};
					end
				end
			end
			default: ;
		endcase
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) result_valid <= 1'b0;
		else         result_valid <= (cmd.op == OP_EMIT);
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_EMIT) begin
			kind      <= kind_q;
			rate_bps  <= rate_q;
			limit_bps <= lim_q;
			severity  <= sev_q;
			case (kind_q)
				KIND_BURST: last <= !stat.susp_hit;
				KIND_SUSP:  last <= !stat.high_hit;
				default:    last <= 1'b1;
			endcase
		end
	end

	always_comb begin
		stat.scan_done = (idx_q == SLOTS_C) && !pend_s1;
		stat.burst_go  = tracked_q && (rate_q > bthr_q) && (cnt_q >= MIN_CNT);
		stat.sum_done  = (sidx_q == cnt_q) && !spend_s1;
		stat.div_done  = (dcnt_q == SUMW_C);
		stat.burst_hit = AW'(rate_q) > prod_q[PW-1:8];
		stat.susp_hit  = rate_q >= sthr_q;
		stat.high_hit  = rate_q > sthr_q;
		stat.sev_done  = !sev_run_q || (scnt_q == 5'(SEV_STEPS));
	end

`ifndef ASSERT_OFF
	a_sev_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> severity <= SEV_FULL)
		else $error("severity above 1.0");
	a_burst_above: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == KIND_BURST |-> rate_bps > limit_bps)
		else $error("burst word with rate not above threshold");
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result words back to back");
`endif

endmodule

// ===== bench/fbad_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbad_checker
// Watches the input, config and result channels of the detector. It keeps its
// own flow table and rate history, predicts the anomaly words and compares.
// ----------------------------------------------------------------------------
module fbad_checker import fbad_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  logic                 func,
	input  logic [31:0]          src_addr,
	input  logic [31:0]          dst_addr,
	input  logic [15:0]          src_port,
	input  logic [15:0]          dst_port,
	input  logic [7:0]           proto,
	input  logic [RATE_W-1:0]    flow_bps,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [RATE_W-1:0]    cfg_data,
	input  logic                 result_valid,
	input  logic [1:0]           kind,
	input  logic [RATE_W-1:0]    rate_bps,
	input  logic [RATE_W-1:0]    limit_bps,
	input  logic [SEV_W-1:0]     severity,
	input  logic                 last,
	output int                   fail_count,
	output int                   outstanding
);

	typedef struct {
		kind_t             kind;
		logic [RATE_W-1:0] rate;
		logic [RATE_W-1:0] limit;
		logic [SEV_W-1:0]  sev;
		logic              last;
	} anomaly_t;

	anomaly_t          anomaly_q[$];
	logic [RATE_W-1:0] burst_thr, susp_thr;
	logic [MULT_W-1:0] burst_mult;
	logic              flow_used [SLOTS_DEF];
	logic [KEY_W-1:0]  flow_key  [SLOTS_DEF];
	logic [RATE_W-1:0] rate_hist [SLOTS_DEF][DEPTH_DEF];
	int                hist_cnt  [SLOTS_DEF];
	int                hist_head [SLOTS_DEF];

	function automatic logic [SEV_W-1:0] sev_q16(logic [RATE_W-1:0] r, logic [RATE_W-1:0] t,
			logic [MULT_W-1:0] m);
		logic [63:0] num, den, rem;
		logic [SEV_W-1:0] q;
		logic carry;
		if (r <= t)
			return '0;
		if (m <= MULT_ONE || t == 0)
			return SEV_FULL;
		num = {8'd0, r - t, 8'd0};
		den = 64'(t) * 64'(m - MULT_ONE);
		if (num >= den)
			return SEV_FULL;
		rem = num;
		q = '0;
		for (int i = 0; i < SEV_STEPS; i++) begin
			carry = rem[63];
			rem = rem << 1;
			q = q << 1;
			if (carry || rem >= den) begin
				rem = rem - den;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	task automatic queue_anomaly(kind_t k, logic [RATE_W-1:0] r, logic [RATE_W-1:0] t,
			logic [MULT_W-1:0] m);
		anomaly_t a;
		a.kind = k;
		a.rate = r;
		a.limit = t;
		a.sev = sev_q16(r, t, m);
		a.last = 1'b0;
		anomaly_q.insert(anomaly_q.size(), a);
	endtask

	// Look up or allocate the flow, append the rate, then queue the hits.
	task automatic predict_sample();
		logic [KEY_W-1:0] key;
		logic [RATE_W-1:0] r;
		logic [63:0] sum, avg;
		int slot, n0;
		key = {src_addr, dst_addr, src_port, dst_port, proto};
		r = flow_bps;
		slot = -1;
		n0 = anomaly_q.size();
		for (int s = 0; s < SLOTS_DEF && slot < 0; s++)
			if (flow_used[s] && flow_key[s] == key)
				slot = s;
		for (int s = 0; s < SLOTS_DEF && slot < 0; s++)
			if (!flow_used[s]) begin
				slot = s;
				flow_used[s] = 1'b1;
				flow_key[s] = key;
				hist_cnt[s] = 0;
				hist_head[s] = 0;
			end
		if (slot >= 0) begin
			rate_hist[slot][hist_head[slot]] = r;
			hist_head[slot] = (hist_head[slot] + 1) % DEPTH_DEF;
			if (hist_cnt[slot] < DEPTH_DEF)
				hist_cnt[slot]++;
			if (r > burst_thr && hist_cnt[slot] >= 3) begin
				sum = '0;
				for (int i = 0; i < hist_cnt[slot]; i++)
					sum += 64'(rate_hist[slot][i]);
				avg = sum / 64'(hist_cnt[slot]);
				if (64'(r) > ((avg * 64'(burst_mult)) >> 8))
					queue_anomaly(KIND_BURST, r, burst_thr, burst_mult);
			end
		end
		if (r >= susp_thr)
			queue_anomaly(KIND_SUSP, r, susp_thr, MULT_SUSP);
		if (r > susp_thr)
			queue_anomaly(KIND_HIGH, r, susp_thr, MULT_HIGH);
		if (anomaly_q.size() > n0)
			anomaly_q[$].last = 1'b1;
	endtask

	function automatic int field_bad(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v === act_v)
			return 0;
		$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		anomaly_t e;
		int bad;
		if (!arst_n) begin
			anomaly_q.delete();
			burst_thr = '0;
			susp_thr = '0;
			burst_mult = MULT_RESET;
			for (int s = 0; s < SLOTS_DEF; s++) begin
				flow_used[s] = 1'b0;
				hist_cnt[s] = 0;
				hist_head[s] = 0;
			end
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_BURST_THR: burst_thr = cfg_data;
					CFG_SUSP_THR:  susp_thr = cfg_data;
					CFG_MULT:      burst_mult = cfg_data[MULT_W-1:0];
					default: ;
				endcase
			end
			// check the word on the ports before any new prediction
			if (result_valid) begin
				if (anomaly_q.size() == 0) begin
					$display("%0t: unexpected word, expected none actual kind %0d rate %0h",
						$time, kind, rate_bps);
					fail_count <= fail_count + 1;
				end else begin
					e = anomaly_q[0];
					anomaly_q.delete(0);
					bad = field_bad("kind", 64'(e.kind), 64'(kind))
						+ field_bad("rate_bps", 64'(e.rate), 64'(rate_bps))
						+ field_bad("limit_bps", 64'(e.limit), 64'(limit_bps))
						+ field_bad("severity", 64'(e.sev), 64'(severity))
						+ field_bad("last", 64'(e.last), 64'(last));
					if (bad != 0)
						fail_count <= fail_count + 1;
				end
			end
			if (start && !busy) begin
				if (func) begin
					for (int s = 0; s < SLOTS_DEF; s++) begin
						flow_used[s] = 1'b0;
						hist_cnt[s] = 0;
						hist_head[s] = 0;
					end
				end else begin
					predict_sample();
				end
			end
			outstanding <= anomaly_q.size();
		end
	end

endmodule

// ===== bench/flow_burst_anomaly_detector_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_burst_anomaly_detector_tb
// Drives flow samples, clear commands and register writes into the detector
// and lets the checker compare every anomaly word; gives the final verdict.
// ----------------------------------------------------------------------------
module flow_burst_anomaly_detector_tb;
	import fbad_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam logic [RATE_W-1:0]    RATE_MAX   = {RATE_W{1'b1}};
	localparam int                   FLOW_POOL  = 6;
	// worst quiet stretch: full table scan, history sum, average division
	// and three severity divisions, plus sender gaps; taken several times
	localparam int                   QUIET_LIMIT = 4000;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic                 func;
	logic [31:0]          src_addr, dst_addr;
	logic [15:0]          src_port, dst_port;
	logic [7:0]           proto;
	logic [RATE_W-1:0]    flow_bps;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [RATE_W-1:0]    cfg_data;
	logic                 result_valid;
	logic [1:0]           kind;
	logic [RATE_W-1:0]    rate_bps, limit_bps;
	logic [SEV_W-1:0]     severity;
	logic                 last;
	int                   fail_count, outstanding;

	int                   burst_left;
	int                   quiet_cycles;
	logic [31:0]          pool_src [FLOW_POOL];
	logic [31:0]          pool_dst [FLOW_POOL];
	logic [15:0]          pool_sp  [FLOW_POOL];
	logic [15:0]          pool_dp  [FLOW_POOL];
	logic [7:0]           pool_pr  [FLOW_POOL];
	logic [RATE_W-1:0]    pool_base[FLOW_POOL];

	flow_burst_anomaly_detector DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.src_addr(src_addr), .dst_addr(dst_addr), .src_port(src_port),
		.dst_port(dst_port), .proto(proto), .flow_bps(flow_bps),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.result_valid(result_valid), .kind(kind), .rate_bps(rate_bps),
		.limit_bps(limit_bps), .severity(severity), .last(last)
	);

	fbad_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.src_addr(src_addr), .dst_addr(dst_addr), .src_port(src_port),
		.dst_port(dst_port), .proto(proto), .flow_bps(flow_bps),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.result_valid(result_valid), .kind(kind), .rate_bps(rate_bps),
		.limit_bps(limit_bps), .severity(severity), .last(last),
		.fail_count(fail_count), .outstanding(outstanding)
	);

	always #10 clk = ~clk;

	// Watchdog: end the run when neither a word goes in nor one comes out
	// for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Present one input word and hold it until it is taken; return at the
	// accepting edge with start still high.
	task automatic send_word(logic f, logic [31:0] sa, logic [31:0] da, logic [15:0] sp,
			logic [15:0] dp, logic [7:0] pr, logic [RATE_W-1:0] bps);
		start <= 1'b1;
		func <= f;
		src_addr <= sa;
		dst_addr <= da;
		src_port <= sp;
		dst_port <= dp;
		proto <= pr;
		flow_bps <= bps;
		do @(posedge clk); while (busy);
	endtask

	// Sender pacing: bursts of random length, random gaps between them.
	// A zero gap keeps start high so back-to-back words see no idle.
	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(0, 9);
			burst_left = $urandom_range(0, 11);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send_paced(logic f, logic [31:0] sa, logic [31:0] da, logic [15:0] sp,
			logic [15:0] dp, logic [7:0] pr, logic [RATE_W-1:0] bps);
		send_word(f, sa, da, sp, dp, pr, bps);
		pace();
	endtask

	task automatic send_pool(int k, logic [RATE_W-1:0] bps);
		send_paced(1'b0, pool_src[k], pool_dst[k], pool_sp[k], pool_dp[k], pool_pr[k], bps);
	endtask

	// Drain: hold off until every expected word has come and the block is
	// idle, then write one register.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [RATE_W-1:0] data);
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0 || busy)
			@(posedge clk);
		repeat (2) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_limits(logic [RATE_W-1:0] b, logic [RATE_W-1:0] s, logic [RATE_W-1:0] m);
		write_reg(CFG_BURST_THR, b);
		write_reg(CFG_SUSP_THR, s);
		write_reg(CFG_MULT, m);
	endtask

	function automatic logic [RATE_W-1:0] rand_wide();
		return RATE_W'({$urandom, $urandom});
	endfunction

	// Mostly steady rates around the flow's base, with spikes, full-range
	// noise and the extremes mixed in.
	function automatic logic [RATE_W-1:0] pool_rate(int k);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return pool_base[k] + RATE_W'($urandom_range(0, 32'(pool_base[k] >> 2)));
		else if (pick < 85)
			return pool_base[k] * RATE_W'($urandom_range(2, 8));
		else if (pick < 93)
			return rand_wide();
		else if (pick < 96)
			return '0;
		return RATE_MAX;
	endfunction

	task automatic random_item();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 5)
			send_paced(1'b1, $urandom, $urandom, 16'($urandom), 16'($urandom), 8'($urandom),
				rand_wide());
		else if (pick < 12)
			send_paced(1'b0, $urandom, $urandom, 16'($urandom), 16'($urandom), 8'($urandom),
				rand_wide());
		else
			begin
				pick = $urandom_range(0, FLOW_POOL - 1);
				send_pool(pick, pool_rate(pick));
			end
	endtask

	initial begin
		clk = 1'b0;
		arst_n <= 1'b0;
		start <= 1'b0;
		func <= 1'b0;
		src_addr <= '0;
		dst_addr <= '0;
		src_port <= '0;
		dst_port <= '0;
		proto <= '0;
		flow_bps <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_BURST_THR;
		cfg_data <= '0;
		burst_left = 0;
		// flows 0 and 1 have complementary all-ones / all-zero address and port fields
		pool_src[0] = '1; pool_dst[0] = '0; pool_sp[0] = '1; pool_dp[0] = '0; pool_pr[0] = 8'd6;
		pool_src[1] = '0; pool_dst[1] = '1; pool_sp[1] = '0; pool_dp[1] = '1; pool_pr[1] = '1;
		for (int k = 0; k < FLOW_POOL; k++) begin
			if (k >= 2) begin
				pool_src[k] = $urandom;
				pool_dst[k] = $urandom;
				pool_sp[k] = 16'($urandom);
				pool_dp[k] = 16'($urandom);
				pool_pr[k] = 8'($urandom);
			end
			pool_base[k] = RATE_W'($urandom_range(1000, 1 << 20));
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: build history, cross thresholds, hit rate limits exactly.
		set_limits(48'd1000, 48'd1000000, 48'(MULT_RESET));
		send_pool(0, 48'd100);
		send_pool(0, 48'd100);
		send_pool(0, 48'd100);
		send_pool(0, 48'd1000);
		send_pool(0, 48'd5000);
		send_pool(0, 48'd1000000);
		send_pool(0, RATE_MAX);
		send_pool(0, '0);
		send_pool(1, '0);
		send_pool(1, 48'd2000000);
		// clear command: history restarts, so no burst on the next sample
		send_paced(1'b1, '1, '1, '1, '1, '1, RATE_MAX);
		send_pool(0, 48'd5000);

		// zero thresholds and a multiplier of exactly 1.0
		set_limits('0, '0, 48'(MULT_ONE));
		send_pool(0, '0);
		send_pool(0, 48'd1);
		send_pool(0, 48'd5000);
		send_pool(0, 48'd7);
		send_pool(1, 48'd3);

		// upper data bits of the multiplier write are dropped; unused index
		set_limits(RATE_MAX, 48'h7FFF_FFFF_FFFF, 48'hABCD_0000_0101);
		write_reg(CFG_UNUSED, RATE_MAX);
		send_pool(0, RATE_MAX);
		send_pool(0, 48'h8000_0000_0000);
		send_pool(1, 48'h7FFF_FFFF_FFFF);

		// multiplier of zero: every rate above the burst threshold bursts once the flow has three samples
		set_limits(48'd10, RATE_MAX, '0);
		send_pool(1, 48'd50);
		send_pool(1, 48'd60);

		// Random phases over several register settings, extremes included.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: set_limits(RATE_W'($urandom_range(0, 1 << 20)),
					RATE_W'($urandom_range(1 << 18, 1 << 23)),
					RATE_W'($urandom_range(257, 1024)));
				1: set_limits('0, RATE_MAX, 48'd257);
				2: set_limits(RATE_MAX, '0, 48'd65535);
				default: set_limits(RATE_W'($urandom_range(0, 1 << 16)),
					RATE_W'($urandom_range(1 << 20, 1 << 30)),
					RATE_W'($urandom_range(257, 65535)));
			endcase
			for (int n = 0; n < 18; n++) begin
				random_item();
				// pause once until every expected word is out
				if (ph == 1 && n == 12) begin
					start <= 1'b0;
					@(posedge clk);
					while (outstanding != 0)
						@(posedge clk);
				end
			end
		end

		// Clear, then restart a flow: the third sample after the clear is
		// the first that can burst.
		set_limits('0, 48'h0100_0000_0000, 48'(MULT_RESET));
		send_paced(1'b1, '0, '0, '0, '0, '0, '0);
		send_pool(0, 48'd10);
		send_pool(0, 48'd10);
		send_pool(0, 48'd100);

		// Drain and let the last word settle before the verdict.
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (500) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
